[src/lkv_pkg.sv]
package lkv_pkg;

    // Default number of entry slots
    localparam int LKV_ENTRIES = 64;

    // Field widths
    localparam int KEY_W     = 64;
    localparam int VAL_W     = 64;
    localparam int MODE_W    = 2;
    localparam int CAP_W     = 7;
    localparam int CNT_OUT_W = 7;

    // Stream widths: key and value in; all result fields out, padded to bytes
    localparam int S_DATA_W = KEY_W + VAL_W;
    localparam int RES_W    = 1 + 1 + VAL_W + 1 + KEY_W + CNT_OUT_W + KEY_W + KEY_W;
    localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Request kinds
    localparam logic [MODE_W-1:0] MODE_GET    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PUT    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_EXISTS = 2'd3;

    // Commit actions chosen by the controller
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_HIT    = 2'd1;
    localparam logic [1:0] ACT_EVICT  = 2'd2;
    localparam logic [1:0] ACT_INSERT = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic       start_search;
        logic       commit;
        logic [1:0] action;
        logic       wr_value;
        logic       start_promote;
        logic       load_out;
    } lkv_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic              scan_busy;
        logic              hit;
        logic              full;
        logic              out_busy;
        logic [MODE_W-1:0] mode;
    } lkv_stat_t;

endpackage

[src/lkv_ram.sv]
module lkv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[src/lkv_ctrl.sv]
module lkv_ctrl
    import lkv_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  lkv_stat_t stat,
    output lkv_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SEARCH  = 3'd1;
    localparam logic [2:0] ST_COMMIT  = 3'd2;
    localparam logic [2:0] ST_PROM_GO = 3'd3;
    localparam logic [2:0] ST_PROMOTE = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] action;
    logic       wr_value;

    // Choose what the request does once the search is over
    always_comb begin
        action   = ACT_NONE;
        wr_value = 1'b0;
        unique case (stat.mode)
            MODE_GET: begin
                action = stat.hit ? ACT_HIT : ACT_NONE;
            end
            MODE_PUT: begin
                wr_value = 1'b1;
                if (stat.hit) begin
                    action = ACT_HIT;
                end else if (stat.full) begin
                    action = ACT_EVICT;
                end else begin
                    action = ACT_INSERT;
                end
            end
            MODE_UPDATE: begin
                wr_value = 1'b1;
                action   = stat.hit ? ACT_HIT : ACT_NONE;
            end
            MODE_EXISTS: begin
                action = ACT_NONE;
            end
            default: begin
                action = ACT_NONE;
            end
        endcase
    end

    // Sequence search, commit, rank update and result hand-off
    always_comb begin
        state_next        = state_reg;
        cmd               = '0;
        cmd.action        = action;
        cmd.wr_value      = wr_value;
        in_ready          = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.start_search = 1'b1;
                    state_next       = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (!stat.scan_busy) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_PROM_GO;
            end
            ST_PROM_GO: begin
                cmd.start_promote = 1'b1;
                state_next        = ST_PROMOTE;
            end
            ST_PROMOTE: begin
                if (!stat.scan_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[src/lkv_datapath.sv]
module lkv_datapath
    import lkv_pkg::*;
#(
    parameter int ENTRIES = LKV_ENTRIES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lkv_cmd_t            cmd,
    output lkv_stat_t           stat,
    input  logic [MODE_W-1:0]   s_tuser,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                cfg_valid,
    input  logic [CAP_W-1:0]    cfg_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int XW = (CW > CAP_W) ? CW : CAP_W;

    // Request held for the duration of its processing
    logic [MODE_W-1:0] req_mode_reg;
    logic [KEY_W-1:0]  req_key_reg;
    logic [VAL_W-1:0]  req_value_reg;

    logic [CW-1:0]    count_reg;
    logic [CAP_W-1:0] capacity_reg;

    // Slot scan
    logic [CW-1:0] scan_cnt_reg;
    logic [CW-1:0] scan_cnt_inc;
    logic          scan_active_reg;
    logic          promote_phase_reg;
    logic          pipe_valid_reg;
    logic [AW-1:0] pipe_idx_reg;

    // Search results
    logic          hit_reg;
    logic [AW-1:0] slot_reg;
    logic [AW-1:0] slot_rank_reg;
    logic [VAL_W-1:0] slot_value_reg;
    logic [AW-1:0] old_slot_reg;
    logic [KEY_W-1:0] old_key_reg;

    // Commit decisions
    logic [AW-1:0] target_reg;
    logic [CW-1:0] limit_reg;
    logic          promote_reg;

    // Result fields
    logic             res_status_reg;
    logic [VAL_W-1:0] res_value_reg;
    logic             res_evicted_reg;
    logic [KEY_W-1:0] res_evk_reg;
    logic [KEY_W-1:0] oldest_reg;
    logic [KEY_W-1:0] newest_reg;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    // Memory ports
    logic [KEY_W-1:0] key_q;
    logic [VAL_W-1:0] val_q;
    logic [AW-1:0]    rank_q;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_slot;
    logic             key_we;
    logic             val_we;
    logic             rank_we;
    logic [AW-1:0]    new_rank;

    logic [CW-1:0]  count_m1;
    logic [AW-1:0]  count_m1_rank;
    logic [XW-1:0]  cap_x;
    logic [XW-1:0]  eff_cap;
    logic [XW-1:0]  count_x;

    assign scan_cnt_inc  = scan_cnt_reg + CW'(1);
    assign rd_addr       = scan_cnt_reg[AW-1:0];
    assign count_m1      = count_reg - CW'(1);
    assign count_m1_rank = count_m1[AW-1:0];
    assign count_x       = XW'(count_reg);

    // Clamp the capacity register to a usable limit
    assign cap_x   = XW'(capacity_reg);
    assign eff_cap = (cap_x == '0) ? XW'(1) :
                     ((cap_x > XW'(ENTRIES)) ? XW'(ENTRIES) : cap_x);

    assign stat.scan_busy = scan_active_reg | pipe_valid_reg;
    assign stat.hit       = hit_reg;
    assign stat.full      = (count_x >= eff_cap);
    assign stat.out_busy  = m_tvalid_reg & ~m_tready;
    assign stat.mode      = req_mode_reg;

    // Pick the slot written at commit
    always_comb begin
        wr_slot = slot_reg;
        key_we  = 1'b0;
        val_we  = 1'b0;
        case (cmd.action)
            ACT_HIT: begin
                val_we = cmd.commit & cmd.wr_value;
            end
            ACT_EVICT: begin
                wr_slot = old_slot_reg;
                key_we  = cmd.commit;
                val_we  = cmd.commit;
            end
            ACT_INSERT: begin
                wr_slot = count_reg[AW-1:0];
                key_we  = cmd.commit;
                val_we  = cmd.commit;
            end
            default: begin
                wr_slot = slot_reg;
            end
        endcase
    end

    // New recency rank for the slot leaving the read pipe
    always_comb begin
        if (promote_reg && (pipe_idx_reg == target_reg)) begin
            new_rank = '0;
        end else if (promote_reg && (CW'(rank_q) < limit_reg)) begin
            new_rank = rank_q + AW'(1);
        end else begin
            new_rank = rank_q;
        end
    end

    assign rank_we = pipe_valid_reg & promote_phase_reg;

    lkv_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .aclk    (aclk),
        .wr_en   (key_we),
        .wr_addr (wr_slot),
        .wr_data (req_key_reg),
        .rd_addr (rd_addr),
        .rd_data (key_q)
    );

    lkv_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
        .aclk    (aclk),
        .wr_en   (val_we),
        .wr_addr (wr_slot),
        .wr_data (req_value_reg),
        .rd_addr (rd_addr),
        .rd_data (val_q)
    );

    lkv_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_rank_ram (
        .aclk    (aclk),
        .wr_en   (rank_we),
        .wr_addr (pipe_idx_reg),
        .wr_data (new_rank),
        .rd_addr (rd_addr),
        .rd_data (rank_q)
    );

    // Control state: count, capacity, scan counter, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg         <= '0;
            capacity_reg      <= CAP_RESET;
            scan_cnt_reg      <= '0;
            scan_active_reg   <= 1'b0;
            promote_phase_reg <= 1'b0;
            pipe_valid_reg    <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_valid && (count_reg == '0)) begin
                capacity_reg <= cfg_data;
            end
            if (cmd.commit && (cmd.action == ACT_INSERT)) begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.start_search || cmd.start_promote) begin
                scan_cnt_reg      <= '0;
                scan_active_reg   <= (count_reg != '0);
                promote_phase_reg <= cmd.start_promote;
            end else if (scan_active_reg) begin
                scan_cnt_reg <= scan_cnt_inc;
                if (scan_cnt_inc == count_reg) begin
                    scan_active_reg <= 1'b0;
                end
            end
            pipe_valid_reg <= scan_active_reg;
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload: request, search results, result fields
    always_ff @(posedge aclk) begin
        pipe_idx_reg <= rd_addr;

        // Latch the request and clear the search result
        if (cmd.start_search) begin
            req_mode_reg  <= s_tuser;
            req_key_reg   <= s_tdata[KEY_W-1:0];
            req_value_reg <= s_tdata[S_DATA_W-1:KEY_W];
            hit_reg       <= 1'b0;
        end

        // Search pass: find the key and the oldest slot
        if (pipe_valid_reg && !promote_phase_reg) begin
            if (key_q == req_key_reg) begin
                hit_reg        <= 1'b1;
                slot_reg       <= pipe_idx_reg;
                slot_rank_reg  <= rank_q;
                slot_value_reg <= val_q;
            end
            if (rank_q == count_m1_rank) begin
                old_slot_reg <= pipe_idx_reg;
                old_key_reg  <= key_q;
            end
        end

        // Commit: fix the target slot, rank limit and result flags
        if (cmd.commit) begin
            target_reg  <= wr_slot;
            promote_reg <= (cmd.action != ACT_NONE);
            case (cmd.action)
                ACT_HIT:    limit_reg <= CW'(slot_rank_reg);
                ACT_EVICT:  limit_reg <= count_m1;
                ACT_INSERT: limit_reg <= count_reg;
                default:    limit_reg <= '0;
            endcase
            res_evicted_reg <= (cmd.action == ACT_EVICT);
            res_evk_reg     <= (cmd.action == ACT_EVICT) ? old_key_reg : '0;
            res_value_reg   <= ((req_mode_reg == MODE_GET) && hit_reg) ?
                               slot_value_reg : '0;
            res_status_reg  <= !hit_reg &&
                               ((req_mode_reg == MODE_GET) || (req_mode_reg == MODE_UPDATE));
            oldest_reg      <= '0;
            newest_reg      <= '0;
        end

        // Rank pass: pick up newest and oldest keys after reordering
        if (rank_we) begin
            if (new_rank == '0) begin
                newest_reg <= key_q;
            end
            if (new_rank == count_m1_rank) begin
                oldest_reg <= key_q;
            end
        end

        // Load the output register
        if (cmd.load_out) begin
            m_tdata_reg <= M_DATA_W'({newest_reg, oldest_reg, count_x[CNT_OUT_W-1:0],
                                      res_evk_reg, res_evicted_reg, res_value_reg,
                                      res_status_reg, hit_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[src/lru_key_value_store_top.sv]
// Fully associative LRU key/value store.
//
// Requests enter on the s_ stream: s_tuser carries the request kind (get, put,
// update, exists), s_tdata the key and the value word. One result per request
// leaves on the m_ stream. Capacity is written on the cfg_ channel, which is
// always ready; a write is taken only while the store is empty.
//
// Requests are handled one at a time. The result follows a search pass and a
// rank pass; for an insert, the second pass also covers the new slot. The next
// request can be accepted as soon as the result is valid. One pass over the
// entry slots reads key, value and rank memories to find the key and the oldest
// slot, a second pass rewrites the recency ranks one slot a cycle and picks up
// the newest and oldest keys. Each memory port does one slot a cycle.
//
// The result sits in an output register; the next request is accepted while
// it waits. A stalled receiver holds the following request at its hand-off
// until the register is free. Reset empties the store and sets the capacity
// to 64 (clamped to the number of slots); no clearing pass is needed.
module lru_key_value_store_top
    import lkv_pkg::*;
#(
    parameter int ENTRIES = LKV_ENTRIES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // key[63:0], value_in[127:64]
    input  logic [MODE_W-1:0]   s_tuser,   // mode[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    // hit[0], status[1], value_out[65:2], evicted[66], evicted_key[130:67],
    // entry_count[137:131], oldest_key[201:138], newest_key[265:202], zero pad
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CAP_W-1:0]    cfg_data
);

    lkv_cmd_t  cmd;
    lkv_stat_t stat;

    assign cfg_ready = 1'b1;

    lkv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lkv_datapath #(.ENTRIES(ENTRIES)) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
